### sv/lmsd_pkg.sv
`default_nettype none

package lmsd_pkg;

   // Operation codes that the front hands to the back.
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_SKIP  = 2'd2
   } op_type;

   // One classified request as it waits in the queue.
   typedef struct packed {
      op_type     op;
      logic [7:0] line;
      logic [7:0] column;
      logic       pixel_bit;
   } req_entry_type;

   // A queue slot as seen on the push side and at the head.
   typedef struct packed {
      logic          valid;
      req_entry_type entry;
   } queue_head_type;

   // Configuration write as it reaches the back.
   typedef struct packed {
      logic        enable;
      logic [1:0]  index;
      logic [11:0] data;
   } csr_write_type;

   // Scan sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_STEP  = 3'b010,
      ST_FETCH = 3'b100
   } back_state_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SLOT_PERIOD  = 2'd0;
   localparam logic [1:0] CSR_BASE_ON_TIME = 2'd1;
   localparam logic [1:0] CSR_ON_TIME_GAIN = 2'd2;

   // Configuration reset values.
   localparam logic [11:0] SLOT_PERIOD_RESET  = 12'd370;
   localparam logic [11:0] BASE_ON_TIME_RESET = 12'd50;
   localparam logic [5:0]  ON_TIME_GAIN_RESET = 6'd5;

   // Request queue geometry.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // Number of set bits in a byte, by pairwise folding.
   function automatic logic [3:0] ones8(input logic [7:0] v);
      logic [7:0] n1;
      logic [7:0] n2;
      logic [7:0] n3;
      n1 = (v & 8'h55) + ((v >> 1) & 8'h55);
      n2 = (n1 & 8'h33) + ((n1 >> 2) & 8'h33);
      n3 = (n2 & 8'h0f) + ((n2 >> 4) & 8'h0f);
      return n3[3:0];
   endfunction

   // Square of a dark-pixel count from 0 to 8.
   function automatic logic [6:0] square_lut(input logic [3:0] c);
      logic [6:0] sq;
      case (c)
         4'd0:    sq = 7'd0;
         4'd1:    sq = 7'd1;
         4'd2:    sq = 7'd4;
         4'd3:    sq = 7'd9;
         4'd4:    sq = 7'd16;
         4'd5:    sq = 7'd25;
         4'd6:    sq = 7'd36;
         4'd7:    sq = 7'd49;
         4'd8:    sq = 7'd64;
         default: sq = 7'd0;
      endcase
      return sq;
   endfunction

endpackage

`default_nettype wire

### sv/lmsd_front.sv
`default_nettype none

module lmsd_front import lmsd_pkg::*; #(
   parameter int LINES   = 16,
   parameter int COLUMNS = 8
) (
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_func,
   input  wire logic signed [7:0] req_pixel_column,
   input  wire logic signed [7:0] req_pixel_line,
   input  wire logic              req_pixel_bit,
   input  wire logic              queue_full,
   output queue_head_type         push
);

   localparam logic [7:0] LINE_BOUND   = 8'(LINES);
   localparam logic [7:0] COLUMN_BOUND = 8'(COLUMNS);

   logic in_range;

   // Negative coordinates have raw codes above every bound, so one unsigned
   // compare per axis covers them.
   assign in_range = ($unsigned(req_pixel_line) < LINE_BOUND) &&
                     ($unsigned(req_pixel_column) < COLUMN_BOUND);

   // Hold the producer off while the queue has no free slot.
   assign req_stall = queue_full;

   // Classify the request and push it into the queue.
   always_comb begin
      push.valid           = req_valid && !queue_full;
      push.entry.line      = $unsigned(req_pixel_line);
      push.entry.column    = $unsigned(req_pixel_column);
      push.entry.pixel_bit = req_pixel_bit;
      if (!req_func) begin
         push.entry.op = OP_TICK;
      end else if (in_range) begin
         push.entry.op = OP_WRITE;
      end else begin
         push.entry.op = OP_SKIP;
      end
   end

endmodule

`default_nettype wire

### sv/lmsd_queue.sv
`default_nettype none

module lmsd_queue import lmsd_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire queue_head_type push,
   output logic                full,
   input  wire logic           pop_ready,
   output queue_head_type      head
);

   req_entry_type          entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = entry_ff[rd_ptr_ff];

   assign do_push = push.valid && !full;
   assign do_pop  = pop_ready && head.valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

`default_nettype wire

### sv/lmsd_back.sv
`default_nettype none

module lmsd_back import lmsd_pkg::*; #(
   parameter int LINES   = 16,
   parameter int COLUMNS = 8
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire csr_write_type  csr,
   input  wire queue_head_type head,
   output logic                pop_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output logic                rsp_drive_active,
   output logic                rsp_upper_half,
   output logic [2:0]          rsp_select_index,
   output logic [7:0]          rsp_column_pattern,
   output logic                rsp_frame_end
);

   localparam int PHASE_W    = $clog2(LINES);
   localparam int COL_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int ITER_LIMIT = 2 * LINES + 2;
   localparam int ITER_W     = $clog2(ITER_LIMIT + 1);

   localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(LINES - 1);
   localparam logic [PHASE_W-1:0] HALF_PHASE = PHASE_W'(LINES / 2);
   localparam logic [ITER_W-1:0]  ITER_END   = ITER_W'(ITER_LIMIT);

   // Configuration registers.
   logic [11:0] slot_period_ff;
   logic [11:0] base_on_time_ff;
   logic [5:0]  on_time_gain_ff;

   // Scan state.
   back_state_type       state_ff;
   back_state_type       state_in;
   logic [PHASE_W-1:0]   phase_ff;
   logic [PHASE_W-1:0]   phase_in;
   logic                 in_drive_ff;
   logic                 in_drive_in;
   logic [12:0]          tick_ff;
   logic [12:0]          tick_in;
   logic [12:0]          prev_on_ff;
   logic [12:0]          prev_on_in;
   logic [COLUMNS-1:0]   latched_ff;
   logic [COLUMNS-1:0]   latched_in;
   logic [ITER_W-1:0]    iter_ff;
   logic [ITER_W-1:0]    iter_in;

   // Result register.
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       drive_ff;
   logic       drive_in;
   logic       upper_ff;
   logic       upper_in;
   logic [2:0] select_ff;
   logic [2:0] select_in;
   logic [7:0] pattern_ff;
   logic [7:0] pattern_in;
   logic       frame_end_ff;
   logic       frame_end_in;

   // Frame store.
   logic [COLUMNS-1:0] frame_mem [LINES];
   logic [LINES-1:0]   line_valid_ff;
   logic [COLUMNS-1:0] rd_data_ff;
   logic               rd_valid_ff;
   logic               mem_we;
   logic               rd_en;
   logic [PHASE_W-1:0] wr_addr;
   logic [PHASE_W-1:0] rd_addr;
   logic [COL_W-1:0]   wr_col;
   logic [COLUMNS-1:0] bit_sel;
   logic [COLUMNS-1:0] wr_mask;
   logic [COLUMNS-1:0] wr_data;

   // Datapath values.
   logic [12:0]        blank_len;
   logic [12:0]        seg_len;
   logic               seg_hit;
   logic [12:0]        tick_next;
   logic               iter_done;
   logic               out_free;
   logic               cur_upper;
   logic [PHASE_W-1:0] cur_rel;
   logic [2:0]         cur_select;
   logic [COLUMNS-1:0] fetched;
   logic [3:0]         dark;
   logic [6:0]         dark_sq;
   logic [12:0]        gain_term;
   logic [12:0]        on_time;

   // Configuration writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_period_ff  <= SLOT_PERIOD_RESET;
         base_on_time_ff <= BASE_ON_TIME_RESET;
         on_time_gain_ff <= ON_TIME_GAIN_RESET;
      end else if (csr.enable) begin
         case (csr.index)
            CSR_SLOT_PERIOD:  slot_period_ff  <= csr.data;
            CSR_BASE_ON_TIME: base_on_time_ff <= csr.data;
            CSR_ON_TIME_GAIN: on_time_gain_ff <= csr.data[5:0];
            default: ;
         endcase
      end
   end

   // Length of the current segment and whether this tick falls inside it.
   assign blank_len = (13'(slot_period_ff) > prev_on_ff) ?
                      13'(slot_period_ff) - prev_on_ff : 13'd0;
   assign seg_len   = in_drive_ff ? prev_on_ff : blank_len;
   assign seg_hit   = (tick_ff < seg_len);
   assign tick_next = tick_ff + 13'd1;
   assign iter_done = (iter_ff == ITER_END);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Half and line select of the current phase.
   assign cur_upper  = (phase_ff >= HALF_PHASE);
   assign cur_rel    = cur_upper ? phase_ff - HALF_PHASE : phase_ff;
   assign cur_select = 3'(cur_rel);

   // On-time of the fetched line: base plus gain times dark count squared.
   assign fetched   = rd_valid_ff ? rd_data_ff : '0;
   assign dark      = 4'(COLUMNS) - ones8(8'(fetched));
   assign dark_sq   = square_lut(dark);
   assign gain_term = 13'({6'd0, dark_sq} * {7'd0, on_time_gain_ff});
   assign on_time   = 13'(14'(base_on_time_ff) + 14'(gain_term));

   // Pixel write addressing; a line not yet written starts from all zero.
   assign wr_addr = head.entry.line[PHASE_W-1:0];
   assign wr_col  = head.entry.column[COL_W-1:0];
   assign bit_sel = COLUMNS'(1) << wr_col;
   assign wr_mask = line_valid_ff[wr_addr] ? bit_sel : '1;
   assign wr_data = line_valid_ff[wr_addr] ? {COLUMNS{head.entry.pixel_bit}} :
                    (head.entry.pixel_bit ? bit_sel : '0);
   assign rd_addr = LAST_PHASE - phase_ff;

   // Sequencer: steps over segment boundaries until the tick lands.
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      in_drive_in  = in_drive_ff;
      tick_in      = tick_ff;
      prev_on_in   = prev_on_ff;
      latched_in   = latched_ff;
      iter_in      = iter_ff;
      pop_ready    = 1'b0;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      drive_in     = drive_ff;
      upper_in     = upper_ff;
      select_in    = select_ff;
      pattern_in   = pattern_ff;
      frame_end_in = frame_end_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid && out_free) begin
               pop_ready = 1'b1;
               case (head.entry.op)
                  OP_TICK: begin
                     state_in = ST_STEP;
                     iter_in  = '0;
                  end
                  OP_WRITE: begin
                     mem_we       = 1'b1;
                     rsp_valid_in = 1'b1;
                     drive_in     = 1'b0;
                     upper_in     = 1'b0;
                     select_in    = '0;
                     pattern_in   = '0;
                     frame_end_in = 1'b0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     drive_in     = 1'b0;
                     upper_in     = 1'b0;
                     select_in    = '0;
                     pattern_in   = '0;
                     frame_end_in = 1'b0;
                  end
               endcase
            end
         end
         ST_STEP: begin
            if (iter_done) begin
               // Every segment was empty: a blank tick of the phase reached.
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  drive_in     = 1'b0;
                  upper_in     = cur_upper;
                  select_in    = cur_select;
                  pattern_in   = '0;
                  frame_end_in = 1'b0;
                  state_in     = ST_IDLE;
               end
            end else if (seg_hit) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  drive_in     = in_drive_ff;
                  upper_in     = cur_upper;
                  select_in    = cur_select;
                  pattern_in   = in_drive_ff ? 8'(latched_ff) : 8'd0;
                  frame_end_in = in_drive_ff && (phase_ff == LAST_PHASE) &&
                                 (tick_next == seg_len);
                  tick_in      = tick_next;
                  state_in     = ST_IDLE;
               end
            end else if (in_drive_ff) begin
               // Drive segment over: move to the next phase.
               in_drive_in = 1'b0;
               tick_in     = '0;
               iter_in     = iter_ff + 1'b1;
               if (phase_ff == LAST_PHASE) begin
                  phase_in   = '0;
                  prev_on_in = '0;
               end else begin
                  phase_in = phase_ff + 1'b1;
               end
            end else begin
               // Blank segment over: fetch the line for the drive segment.
               rd_en    = 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            latched_in  = fetched;
            prev_on_in  = on_time;
            in_drive_in = 1'b1;
            tick_in     = '0;
            iter_in     = iter_ff + 1'b1;
            state_in    = ST_STEP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= '0;
         in_drive_ff   <= 1'b0;
         tick_ff       <= '0;
         prev_on_ff    <= '0;
         latched_ff    <= '0;
         iter_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         line_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         in_drive_ff  <= in_drive_in;
         tick_ff      <= tick_in;
         prev_on_ff   <= prev_on_in;
         latched_ff   <= latched_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mem_we) begin
            line_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      drive_ff     <= drive_in;
      upper_ff     <= upper_in;
      select_ff    <= select_in;
      pattern_ff   <= pattern_in;
      frame_end_ff <= frame_end_in;
   end

   // Frame store with per-bit write and registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         for (int j = 0; j < COLUMNS; j++) begin
            if (wr_mask[j]) begin
               frame_mem[wr_addr][j] <= wr_data[j];
            end
         end
      end
      if (rd_en) begin
         rd_data_ff  <= frame_mem[rd_addr];
         rd_valid_ff <= line_valid_ff[rd_addr];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_drive_active   = drive_ff;
   assign rsp_upper_half     = upper_ff;
   assign rsp_select_index   = select_ff;
   assign rsp_column_pattern = pattern_ff;
   assign rsp_frame_end      = frame_end_ff;

endmodule

`default_nettype wire

### sv/led_matrix_scan_driver.sv
`default_nettype none

// Scan driver for a multiplexed LED matrix of LINES lines by COLUMNS columns.
// Each request is either a one-microsecond tick or a pixel write, and each
// gives exactly one response: a pixel write answers with all fields zero, a
// tick with the drive state of that microsecond. A phase blanks for the slot
// period less the previous on-time, then drives its line for base on-time
// plus gain times the square of the line's dark-pixel count. Requests pass
// through a two-entry queue to a sequencer that handles one request at a
// time. A tick steps over segment boundaries in the sequencer until it
// falls in the current segment; each line that it enters passes through a
// fetch state for the registered read of the frame store. The frame store
// powers up cleared through per-line valid bits, so there is no clearing
// pass after reset. Configuration must be written only while no request is
// in flight.
module led_matrix_scan_driver import lmsd_pkg::*; #(
   parameter int LINES   = 16,
   parameter int COLUMNS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_func,
   input  wire logic signed [7:0] req_pixel_column,
   input  wire logic signed [7:0] req_pixel_line,
   input  wire logic              req_pixel_bit,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_drive_active,
   output logic                   rsp_upper_half,
   output logic [2:0]             rsp_select_index,
   output logic [7:0]             rsp_column_pattern,
   output logic                   rsp_frame_end,
   input  wire logic              csr_write_enable,
   input  wire logic [1:0]        csr_index,
   input  wire logic [11:0]       csr_write_data
);

   // The last phase sits in the upper half; its select is its offset from the half.
   localparam logic [2:0] LAST_SELECT = 3'((LINES - 1 - LINES / 2) % 8);

   queue_head_type push;
   queue_head_type head;
   logic           queue_full;
   logic           pop_ready;
   csr_write_type  csr;

   assign csr.enable = csr_write_enable;
   assign csr.index  = csr_index;
   assign csr.data   = csr_write_data;

   // Front end: accept and classify requests.
   lmsd_front #(
      .LINES   (LINES),
      .COLUMNS (COLUMNS)
   ) u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_pixel_column (req_pixel_column),
      .req_pixel_line   (req_pixel_line),
      .req_pixel_bit    (req_pixel_bit),
      .queue_full       (queue_full),
      .push             (push)
   );

   // Queue between front end and sequencer.
   lmsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (queue_full),
      .pop_ready (pop_ready),
      .head      (head)
   );

   // Back end: frame store, scan sequencer and response register.
   lmsd_back #(
      .LINES   (LINES),
      .COLUMNS (COLUMNS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .csr                (csr),
      .head               (head),
      .pop_ready          (pop_ready),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_drive_active   (rsp_drive_active),
      .rsp_upper_half     (rsp_upper_half),
      .rsp_select_index   (rsp_select_index),
      .rsp_column_pattern (rsp_column_pattern),
      .rsp_frame_end      (rsp_frame_end)
   );

   // Frame end only comes on a drive tick of the last phase.
   a_frame_end_last_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |->
         rsp_drive_active && rsp_upper_half && (rsp_select_index == LAST_SELECT))
      else $error("frame end outside a drive tick of the last phase");

   // A blank response carries no pattern and no frame end.
   a_blank_is_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_drive_active |->
         (rsp_column_pattern == 8'd0) && !rsp_frame_end)
      else $error("blank response with pattern or frame end");

   // The queue only pushes back once it holds requests for the sequencer.
   a_stall_has_work: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> head.valid)
      else $error("request stalled while the queue is empty");

endmodule

`default_nettype wire

### tb/led_matrix_scan_checker.sv
`timescale 1ns / 100ps

// Watches the request, response and register ports of the scan driver. It keeps
// its own copy of the frame store, the scan position and the registers. For
// every accepted request it computes the response the block owes, and it
// compares each accepted response with the oldest one still owed.
module led_matrix_scan_checker import lmsd_pkg::*; #(
   parameter int LINES   = 16,
   parameter int COLUMNS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_pixel_column,
   input  logic [7:0]  req_pixel_line,
   input  logic        req_pixel_bit,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_drive_active,
   input  logic        rsp_upper_half,
   input  logic [2:0]  rsp_select_index,
   input  logic [7:0]  rsp_column_pattern,
   input  logic        rsp_frame_end,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_write_data,
   output int          mismatches,
   output int          outstanding
);

   localparam int PHASE_W    = $clog2(LINES);
   localparam int SEARCH_MAX = 2 * LINES + 2;
   localparam int REPORT_MAX = 200;

   // One response of the block.
   typedef struct packed {
      logic       drive_active;
      logic       upper_half;
      logic [2:0] select_index;
      logic [7:0] column_pattern;
      logic       frame_end;
   } scan_out_type;

   // Register copies.
   logic [11:0]        slot_period;
   logic [11:0]        base_on_time;
   logic [5:0]         on_time_gain;

   // Scan state copies.
   logic [7:0]         frame_store [LINES];
   logic [PHASE_W-1:0] phase_index;
   logic               in_drive;
   logic [12:0]        tick_count;
   logic [12:0]        last_on_time;
   logic [7:0]         shown_pattern;

   scan_out_type       scan_outputs_due [$];
   int                 error_count = 0;

   // Number of dark pixels in one line.
   function automatic int dark_count(input logic [7:0] row);
      int n;
      n = 0;
      for (int b = 0; b < COLUMNS; b++)
         if (!row[b])
            n++;
      return n;
   endfunction

   // Moves the scan on by one microsecond and works out what it shows.
   // Empty segments are passed over without using up the tick.
   task automatic advance_scan(output scan_out_type shown);
      logic [12:0] seg_len;
      logic        hit;
      int          dark;
      int          on_ticks;
      int          half_phase;
      hit   = 1'b0;
      shown = '0;
      for (int n = 0; n < SEARCH_MAX && !hit; n++) begin
         if (in_drive)
            seg_len = last_on_time;
         else if ({1'b0, slot_period} > last_on_time)
            seg_len = {1'b0, slot_period} - last_on_time;
         else
            seg_len = '0;

         if (tick_count < seg_len) begin
            hit                  = 1'b1;
            shown.drive_active   = in_drive;
            shown.column_pattern = in_drive ? shown_pattern : 8'h00;
            shown.frame_end      = in_drive && int'(phase_index) == LINES - 1 &&
                                   tick_count == seg_len - 13'd1;
         end else if (in_drive) begin
            // Drive is over: next phase, and a fresh frame after the last one.
            if (int'(phase_index) == LINES - 1) begin
               phase_index  = '0;
               last_on_time = '0;
            end else begin
               phase_index = phase_index + 1'b1;
            end
            in_drive   = 1'b0;
            tick_count = '0;
         end else begin
            // Blanking is over: latch the line and its on-time.
            shown_pattern = frame_store[LINES - 1 - phase_index];
            dark          = dark_count(shown_pattern);
            on_ticks      = int'(base_on_time) + int'(on_time_gain) * dark * dark;
            last_on_time  = on_ticks[12:0];
            in_drive      = 1'b1;
            tick_count    = '0;
         end
      end

      shown.upper_half   = int'(phase_index) >= LINES / 2;
      half_phase         = int'(phase_index) - (shown.upper_half ? LINES / 2 : 0);
      shown.select_index = half_phase[2:0];
      if (hit)
         tick_count = tick_count + 13'd1;
   endtask

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         error_count++;
         if (error_count <= REPORT_MAX)
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      scan_out_type due;
      if (reset) begin
         slot_period   = SLOT_PERIOD_RESET;
         base_on_time  = BASE_ON_TIME_RESET;
         on_time_gain  = ON_TIME_GAIN_RESET;
         for (int i = 0; i < LINES; i++)
            frame_store[i] = '0;
         phase_index   = '0;
         in_drive      = 1'b0;
         tick_count    = '0;
         last_on_time  = '0;
         shown_pattern = '0;
         scan_outputs_due.delete();
      end else begin
         // A response belongs to an older request, so it is checked first.
         if (rsp_valid && !rsp_stall) begin
            if (scan_outputs_due.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_MAX)
                  $display("%0t: unexpected response, drive %0b half %0b select %0d %s %02h %0b",
                           $time, rsp_drive_active, rsp_upper_half, rsp_select_index,
                           "pattern/frame end", rsp_column_pattern, rsp_frame_end);
            end else begin
               due = scan_outputs_due.pop_front();
               check_field("drive_active", due.drive_active, rsp_drive_active);
               check_field("upper_half", due.upper_half, rsp_upper_half);
               check_field("select_index", due.select_index, rsp_select_index);
               check_field("column_pattern", due.column_pattern, rsp_column_pattern);
               check_field("frame_end", due.frame_end, rsp_frame_end);
            end
         end

         // Register writes; an unused index changes nothing.
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SLOT_PERIOD:  slot_period  = csr_write_data;
               CSR_BASE_ON_TIME: base_on_time = csr_write_data;
               CSR_ON_TIME_GAIN: on_time_gain = csr_write_data[5:0];
               default: ;
            endcase
         end

         // A pixel write answers with all zero; a tick answers with the scan.
         if (req_valid && !req_stall) begin
            if (op_type'({1'b0, req_func}) == OP_WRITE) begin
               if (req_pixel_column < COLUMNS && req_pixel_line < LINES)
                  frame_store[req_pixel_line][req_pixel_column] = req_pixel_bit;
               due = '0;
            end else begin
               advance_scan(due);
            end
            scan_outputs_due.push_back(due);
         end
      end
      mismatches  <= error_count;
      outstanding <= scan_outputs_due.size();
   end

endmodule

### tb/tb_led_matrix_scan_driver.sv
`timescale 1ns / 100ps

module tb_led_matrix_scan_driver import lmsd_pkg::*;;

   localparam int LINES          = 16;
   localparam int COLUMNS        = 8;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 3 * LINES + 13;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_func;
   logic signed [7:0] req_pixel_column;
   logic signed [7:0] req_pixel_line;
   logic              req_pixel_bit;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_drive_active;
   logic              rsp_upper_half;
   logic [2:0]        rsp_select_index;
   logic [7:0]        rsp_column_pattern;
   logic              rsp_frame_end;
   logic              csr_write_enable;
   logic [1:0]        csr_index;
   logic [11:0]       csr_write_data;

   int                mismatches;
   int                outstanding;
   int                quiet_cycles = 0;
   logic              hold_req;
   logic              gaps_on;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   led_matrix_scan_driver #(
      .LINES   (LINES),
      .COLUMNS (COLUMNS)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_pixel_column   (req_pixel_column),
      .req_pixel_line     (req_pixel_line),
      .req_pixel_bit      (req_pixel_bit),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_drive_active   (rsp_drive_active),
      .rsp_upper_half     (rsp_upper_half),
      .rsp_select_index   (rsp_select_index),
      .rsp_column_pattern (rsp_column_pattern),
      .rsp_frame_end      (rsp_frame_end),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   led_matrix_scan_checker #(
      .LINES   (LINES),
      .COLUMNS (COLUMNS)
   ) scan_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_pixel_column   (req_pixel_column),
      .req_pixel_line     (req_pixel_line),
      .req_pixel_bit      (req_pixel_bit),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_drive_active   (rsp_drive_active),
      .rsp_upper_half     (rsp_upper_half),
      .rsp_select_index   (rsp_select_index),
      .rsp_column_pattern (rsp_column_pattern),
      .rsp_frame_end      (rsp_frame_end),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .mismatches         (mismatches),
      .outstanding        (outstanding)
   );

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 60)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offers one request after a random gap and returns at the edge that takes it.
   task automatic send_item(input op_type op, input logic [7:0] col, input logic [7:0] line,
                            input logic pbit);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= (op == OP_WRITE);
      req_pixel_column <= col;
      req_pixel_line   <= line;
      req_pixel_bit    <= pbit;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Stops offering and waits until every owed response has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   // Writes all three registers, plus one write to the unused index, while idle.
   task automatic set_config(input logic [11:0] slot, input logic [11:0] base,
                             input logic [5:0] gain);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SLOT_PERIOD;
      csr_write_data   <= slot;
      @(posedge clock);
      csr_index        <= CSR_BASE_ON_TIME;
      csr_write_data   <= base;
      @(posedge clock);
      // Bits above the gain field must be dropped.
      csr_index        <= CSR_ON_TIME_GAIN;
      csr_write_data   <= {6'($urandom_range(0, 63)), gain};
      @(posedge clock);
      csr_index        <= CSR_UNUSED;
      csr_write_data   <= 12'($urandom);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Random mix of ticks and pixel writes. Most writes land in range, a fair
   // share on line 0, which phase 15 shows; one_pct biases the pixel value.
   task automatic random_phase(input int count, input int write_pct, input int one_pct,
                               input int hold_at, input int pause_at);
      logic [7:0] col;
      logic [7:0] line;
      int         r;
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0)
            gaps_on <= ($urandom_range(0, 3) != 0);
         if (i == hold_at)
            hold_req <= 1'b1;
         if (i == pause_at)
            drain();
         r = $urandom_range(0, 99);
         if (r < write_pct) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
               col  = 8'($urandom_range(0, 255));
               line = 8'($urandom_range(0, 255));
            end else begin
               col  = 8'($urandom_range(0, COLUMNS - 1));
               line = (r < 40) ? 8'd0 : 8'($urandom_range(0, LINES - 1));
            end
            send_item(OP_WRITE, col, line, $urandom_range(0, 99) < one_pct);
         end else begin
            send_item(OP_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
         end
      end
   endtask

   // Response side: random stalls, and one long hold-off once it is requested.
   initial begin : receiver
      int   stall_left;
      int   hold_left;
      logic hold_taken;
      stall_left = 0;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (stall_left == 0)
               stall_left = idle_cycles();
            rsp_stall <= (stall_left > 0);
            if (stall_left > 0)
               stall_left--;
         end
      end
   end

   // Ends the run when neither channel nor the register port moves for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** led_matrix_scan_driver: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_func         <= 1'b0;
      req_pixel_column <= '0;
      req_pixel_line   <= '0;
      req_pixel_bit    <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_SLOT_PERIOD;
      csr_write_data   <= '0;
      hold_req         <= 1'b0;
      gaps_on          <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed, at reset settings: corner pixels, then columns and lines out of
      // range on both sides (positive overflow and negative), then a clear.
      send_item(OP_WRITE, 8'd0, 8'd0, 1'b1);
      send_item(OP_WRITE, 8'd7, 8'd15, 1'b1);
      send_item(OP_WRITE, 8'd7, 8'd0, 1'b1);
      send_item(OP_WRITE, 8'd8, 8'd0, 1'b1);
      send_item(OP_WRITE, 8'hff, 8'd3, 1'b1);
      send_item(OP_WRITE, 8'h80, 8'd5, 1'b1);
      send_item(OP_WRITE, 8'h7f, 8'd2, 1'b1);
      send_item(OP_WRITE, 8'd3, 8'd16, 1'b1);
      send_item(OP_WRITE, 8'd3, 8'hff, 1'b1);
      send_item(OP_WRITE, 8'd3, 8'h80, 1'b1);
      send_item(OP_WRITE, 8'd3, 8'h7f, 1'b1);
      send_item(OP_WRITE, 8'd0, 8'd0, 1'b0);
      send_item(OP_TICK, 8'hff, 8'hff, 1'b1);
      send_item(OP_TICK, 8'h00, 8'h00, 1'b0);
      send_item(OP_TICK, 8'h80, 8'h7f, 1'b1);

      // Short phases so that frames complete; includes the long receiver hold.
      set_config(12'd4, 12'd2, 6'd0);
      random_phase(200, 35, 85, 60, -1);

      // No blanking at all; fully lit lines get an empty drive.
      set_config(12'd0, 12'd0, 6'd1);
      random_phase(150, 30, 90, -1, -1);

      // Brightness compensation at work; the sender pauses midway until idle.
      set_config(12'd10, 12'd1, 6'd1);
      random_phase(150, 35, 50, -1, 75);

      // Every drive is empty, so a frame never ends with a drive tick.
      set_config(12'd3, 12'd0, 6'd0);
      random_phase(80, 30, 50, -1, -1);

      // Nothing anywhere to show: every tick is a blank tick.
      set_config(12'd0, 12'd0, 6'd0);
      random_phase(40, 30, 50, -1, -1);

      // Drive longer than the slot, mostly dark lines.
      set_config(12'd1, 12'd3, 6'd0);
      random_phase(100, 35, 20, -1, -1);

      // Largest settings.
      set_config(12'hfff, 12'hfff, 6'h3f);
      random_phase(40, 30, 50, -1, -1);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("** led_matrix_scan_driver: PASSED **");
      else
         $display("** led_matrix_scan_driver: FAILED **");
      $finish;
   end

endmodule
